@@ rtl/core/dba_pkg.sv @@
// dba_pkg: shared constants, codes, engine result type and the
// first-free bit finder for the disk block allocator.
// No dependencies.
`default_nettype none

package dba_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int SCAN_WIDTH = 32;
    localparam int ROWS       = MAX_BLOCKS / SCAN_WIDTH;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int ROWS_W     = $clog2(ROWS + 1);
    localparam int BIT_W      = $clog2(SCAN_WIDTH);

    localparam int BLK_W      = 10;
    localparam int CNT_W      = 11;
    localparam int BYTES_W    = 17;
    localparam int BYTE_CNT_W = 32;
    localparam int PROD_W     = CNT_W + BYTES_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 17;

    localparam logic [BYTES_W-1:0] BLOCK_BYTES_RESET = BYTES_W'(512);
    localparam logic [CNT_W-1:0]   BLOCK_COUNT_RESET = CNT_W'(1024);

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_SPACE     = 2'd1,
        ST_ALREADY_FREE = 2'd2,
        ST_RANGE        = 2'd3
    } t_status;

    typedef struct packed {
        logic             done;
        logic             query;
        logic [BLK_W-1:0] granted;
        t_status          status;
    } t_eng_res;

    function automatic logic [BIT_W-1:0] first_set(input logic [SCAN_WIDTH-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int k = SCAN_WIDTH - 1; k >= 0; k--) begin
            if (v[k]) begin
                idx = BIT_W'(k);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/disk_block_allocator_core.sv @@
// disk_block_allocator_core: first-fit disk block allocator top level.
// Allocate: busy through a fetch state and one scan state per row searched; not busy with no blocks.
// Free: busy through fetch and check states; query, out-of-range free, unknown command: not busy.
// Result strobe follows the engine by one output register; receiver cannot stall.
// Synchronous active-low reset: all blocks free, block_bytes 512, block_count 1024.
// Depends on dba_pkg and dba_engine.
`default_nettype none

module disk_block_allocator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [1:0]                     i_cmd,
    input  logic [dba_pkg::BLK_W-1:0]      i_block_number,
    input  logic [dba_pkg::BYTE_CNT_W-1:0] i_byte_count,
    input  logic                           i_cfg_we,
    input  logic [dba_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dba_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                           o_done,
    output logic [dba_pkg::BLK_W-1:0]      o_granted_block,
    output logic [1:0]                     o_status,
    output logic                           o_space_ok
);
    import dba_pkg::*;

    logic [BYTES_W-1:0]    r_block_bytes;
    logic [CNT_W-1:0]      r_block_count;
    logic [BYTE_CNT_W-1:0] r_byte_count;
    logic [PROD_W-1:0]     r_have;
    logic                  r_done;
    logic [BLK_W-1:0]      r_granted;
    t_status               r_status;
    logic                  r_space;

    logic [CNT_W-1:0] w_live;
    logic [CNT_W-1:0] w_cfg_count;
    logic [CNT_W-1:0] w_clear_count;
    logic             w_clear;
    logic [CNT_W-1:0] w_free;
    logic             w_accept;
    t_eng_res         w_res;

    assign w_live = (r_block_count > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                         : r_block_count;
    assign w_cfg_count   = i_cfg_data[CNT_W-1:0];
    assign w_clear_count = (w_cfg_count > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                              : w_cfg_count;
    assign w_clear  = i_cfg_we && (i_cfg_idx == CFG_BLOCK_COUNT);
    assign w_accept = i_start && !o_busy;

    dba_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_accept),
        .i_cmd          (i_cmd),
        .i_block_number (i_block_number),
        .i_live         (w_live),
        .i_clear        (w_clear),
        .i_clear_count  (w_clear_count),
        .o_busy         (o_busy),
        .o_free_blocks  (w_free),
        .o_res          (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= BLOCK_BYTES_RESET;
            r_block_count <= BLOCK_COUNT_RESET;
            r_done        <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == CFG_BLOCK_BYTES)) begin
                r_block_bytes <= i_cfg_data[BYTES_W-1:0];
            end
            if (w_clear) begin
                r_block_count <= w_cfg_count;
            end
            r_done <= w_res.done;
        end
    end

    // free byte total, tracked every cycle; also latches the request byte count and the engine result
    always_ff @(posedge i_clk) begin
        r_have <= PROD_W'(w_free) * PROD_W'(r_block_bytes);
        if (w_accept) begin
            r_byte_count <= i_byte_count;
        end
        if (w_res.done) begin
            r_granted <= w_res.granted;
            r_status  <= w_res.status;
            r_space   <= w_res.query && (BYTE_CNT_W'(r_have) >= r_byte_count);
        end
    end

    assign o_done          = r_done;
    assign o_granted_block = r_granted;
    assign o_status        = r_status;
    assign o_space_ok      = r_space;

`ifndef SYNTHESIS
    a_free_le_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_free <= w_live)
        else $error("free count above live block count");

    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_busy || w_res.done))
        else $error("accepted beat neither busy nor finished");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.done |-> !o_busy)
        else $error("engine finished while still busy");
`endif

endmodule

`default_nettype wire

@@ rtl/core/dba_ram.sv @@
// dba_ram: generic single write port, single read port RAM with
// registered read data. No dependencies.
`default_nettype none

module dba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/dba_engine.sv @@
// dba_engine: request sequencer over the used-mark RAM, row valid bits
// and free block count. Scans one mark row per cycle for allocate.
// Depends on dba_pkg and dba_ram.
`default_nettype none

module dba_engine (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [1:0]                i_cmd,
    input  logic [dba_pkg::BLK_W-1:0] i_block_number,
    input  logic [dba_pkg::CNT_W-1:0] i_live,
    input  logic                      i_clear,
    input  logic [dba_pkg::CNT_W-1:0] i_clear_count,
    output logic                      o_busy,
    output logic [dba_pkg::CNT_W-1:0] o_free_blocks,
    output dba_pkg::t_eng_res         o_res
);
    import dba_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_SCAN  = 4'b0100,
        S_CHECK = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [ROW_W-1:0]  r_ptr, n_ptr;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic              r_is_free, n_is_free;
    logic [ROWS-1:0]   r_valid, n_valid;
    logic [CNT_W-1:0]  r_free, n_free;
    t_eng_res          r_res, n_res;

    logic [ROWS_W-1:0]     w_words;
    logic [CNT_W-1:0]      w_rem;
    logic [SCAN_WIDTH-1:0] w_rdata;
    logic [SCAN_WIDTH-1:0] w_word;
    logic [SCAN_WIDTH-1:0] w_beyond;
    logic [SCAN_WIDTH-1:0] w_zero;
    logic                  w_hit;
    logic                  w_last;
    logic [BIT_W-1:0]      w_k;
    logic                  w_we;
    logic [SCAN_WIDTH-1:0] w_wdata;
    logic [ROW_W-1:0]      w_raddr;

    dba_ram #(
        .WIDTH (SCAN_WIDTH),
        .DEPTH (ROWS)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_ptr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_words = ROWS_W'((i_live + CNT_W'(SCAN_WIDTH - 1)) >> BIT_W);
    assign w_rem   = i_live - CNT_W'({r_ptr, {BIT_W{1'b0}}});
    assign w_word  = r_valid[r_ptr] ? w_rdata : '0;

    always_comb begin
        for (int k = 0; k < SCAN_WIDTH; k++) begin
            w_beyond[k] = CNT_W'(k) >= w_rem;
        end
    end

    assign w_zero = ~(w_word | w_beyond);
    assign w_hit  = |w_zero;
    assign w_k    = first_set(w_zero);
    assign w_last = (ROWS_W'(r_ptr) + ROWS_W'(1)) == w_words;

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_bit     = r_bit;
        n_is_free = r_is_free;
        n_valid   = r_valid;
        n_free    = r_free;
        n_res     = r_res;
        n_res.done = 1'b0;
        w_we      = 1'b0;
        w_wdata   = w_word;
        w_raddr   = r_ptr;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_res.query   = 1'b0;
                    n_res.granted = '0;
                    n_res.status  = ST_OK;
                    case (t_cmd'(i_cmd))
                        CMD_ALLOC: begin
                            if (w_words == '0) begin
                                n_res.done   = 1'b1;
                                n_res.status = ST_NO_SPACE;
                            end else begin
                                n_ptr     = '0;
                                n_is_free = 1'b0;
                                n_state   = S_FETCH;
                            end
                        end
                        CMD_FREE: begin
                            if (CNT_W'(i_block_number) >= i_live) begin
                                n_res.done   = 1'b1;
                                n_res.status = ST_RANGE;
                            end else begin
                                n_ptr     = i_block_number[BIT_W +: ROW_W];
                                n_bit     = i_block_number[BIT_W-1:0];
                                n_is_free = 1'b1;
                                n_state   = S_FETCH;
                            end
                        end
                        CMD_QUERY: begin
                            n_res.done  = 1'b1;
                            n_res.query = 1'b1;
                        end
                        default: begin
                            n_res.done = 1'b1;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                n_state = r_is_free ? S_CHECK : S_SCAN;
            end
            S_SCAN: begin
                // prefetch the next row while this one is searched
                w_raddr = r_ptr + ROW_W'(1);
                if (w_hit) begin
                    w_we             = 1'b1;
                    w_wdata          = w_word | (SCAN_WIDTH'(1) << w_k);
                    n_valid[r_ptr]   = 1'b1;
                    if (r_free != '0) begin
                        n_free = r_free - CNT_W'(1);
                    end
                    n_res.done    = 1'b1;
                    n_res.granted = BLK_W'({r_ptr, w_k});
                    n_state       = S_IDLE;
                end else if (w_last) begin
                    n_res.done   = 1'b1;
                    n_res.status = ST_NO_SPACE;
                    n_state      = S_IDLE;
                end else begin
                    n_ptr = r_ptr + ROW_W'(1);
                end
            end
            S_CHECK: begin
                if (!w_word[r_bit]) begin
                    n_res.status = ST_ALREADY_FREE;
                end else begin
                    w_we           = 1'b1;
                    w_wdata        = w_word & ~(SCAN_WIDTH'(1) << r_bit);
                    n_valid[r_ptr] = 1'b1;
                    n_free         = r_free + CNT_W'(1);
                end
                n_res.done = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_clear) begin
            n_valid = '0;
            n_free  = i_clear_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ptr     <= '0;
            r_bit     <= '0;
            r_is_free <= 1'b0;
            r_valid   <= '0;
            r_free    <= CNT_W'(MAX_BLOCKS);
            r_res     <= '0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_bit     <= n_bit;
            r_is_free <= n_is_free;
            r_valid   <= n_valid;
            r_free    <= n_free;
            r_res     <= n_res;
        end
    end

    assign o_busy        = r_state != S_IDLE;
    assign o_free_blocks = r_free;
    assign o_res         = r_res;

endmodule

`default_nettype wire

@@ tb/disk_block_allocator_core_tb.sv @@
`timescale 1ns / 100ps
// disk_block_allocator_core_tb: self-checking bench for the first-fit block allocator.
// Runs a directed table, then random request phases under changing register settings,
// and checks each reply against table or predicted values. Depends on dba_pkg and the core.
module disk_block_allocator_core_tb;
    import dba_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_ITEMS    = 110;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_3 = CFG_IDX_W'(3);

    typedef struct packed {
        logic [BLK_W-1:0] granted;
        t_status          status;
        logic             space_ok;
    } reply_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        t_cmd                  cmd;
        logic [BLK_W-1:0]      blk;
        logic [BYTE_CNT_W-1:0] bytes;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_W-1:0]      data;
        logic                  checked;
        reply_t                want;
    } plan_row_t;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_start        = 1'b0;
    logic [1:0]            i_cmd          = 2'b0;
    logic [BLK_W-1:0]      i_block_number = '0;
    logic [BYTE_CNT_W-1:0] i_byte_count   = '0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = '0;
    logic [CFG_W-1:0]      i_cfg_data     = '0;
    logic                  o_busy;
    logic                  o_done;
    logic [BLK_W-1:0]      o_granted_block;
    logic [1:0]            o_status;
    logic                  o_space_ok;

    logic             block_taken [MAX_BLOCKS];
    int               free_left;
    logic [BYTES_W-1:0] size_per_block;
    logic [CNT_W-1:0] count_reg;

    reply_t    awaited[$];
    plan_row_t plan[$];
    int        errors     = 0;
    int        quiet      = 0;
    int        burst_left = 0;
    logic      steady     = 1'b0;

    disk_block_allocator_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_cmd           (i_cmd),
        .i_block_number  (i_block_number),
        .i_byte_count    (i_byte_count),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_granted_block (o_granted_block),
        .o_status        (o_status),
        .o_space_ok      (o_space_ok)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int live_blocks();
        return (int'(count_reg) > MAX_BLOCKS) ? MAX_BLOCKS : int'(count_reg);
    endfunction

    function automatic void clear_marks();
        foreach (block_taken[b]) block_taken[b] = 1'b0;
        free_left = live_blocks();
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_BLOCK_BYTES: size_per_block = data[BYTES_W-1:0];
            CFG_BLOCK_COUNT: begin
                count_reg = data[CNT_W-1:0];
                clear_marks();
            end
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] free_bytes();
        logic [63:0] have;
        have = 64'(free_left) * 64'(size_per_block);
        return have[31:0];
    endfunction

    function automatic reply_t serve_request(t_cmd cmd, logic [BLK_W-1:0] blk,
                                             logic [BYTE_CNT_W-1:0] bytes);
        reply_t      r;
        int          slot;
        logic [63:0] have;
        r.granted  = '0;
        r.status   = ST_OK;
        r.space_ok = 1'b0;
        case (cmd)
            CMD_ALLOC: begin
                slot = -1;
                for (int b = 0; b < live_blocks() && slot < 0; b++) begin
                    if (!block_taken[b]) slot = b;
                end
                if (slot < 0) begin
                    r.status = ST_NO_SPACE;
                end else begin
                    block_taken[slot] = 1'b1;
                    if (free_left > 0) free_left--;
                    r.granted = BLK_W'(slot);
                end
            end
            CMD_FREE: begin
                if (int'(blk) >= live_blocks()) begin
                    r.status = ST_RANGE;
                end else if (!block_taken[blk]) begin
                    r.status = ST_ALREADY_FREE;
                end else begin
                    block_taken[blk] = 1'b0;
                    free_left = (free_left + 1) & 'h7FF;
                end
            end
            CMD_QUERY: begin
                have = 64'(free_left) * 64'(size_per_block);
                r.space_ok = (have >= 64'(bytes));
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic plan_row_t ask(t_cmd cmd, logic [BLK_W-1:0] blk,
                                      logic [BYTE_CNT_W-1:0] bytes);
        plan_row_t row;
        row.kind    = ROW_REQ;
        row.cmd     = cmd;
        row.blk     = blk;
        row.bytes   = bytes;
        row.idx     = '0;
        row.data    = '0;
        row.checked = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    function automatic plan_row_t ask_chk(t_cmd cmd, logic [BLK_W-1:0] blk,
                                          logic [BYTE_CNT_W-1:0] bytes,
                                          logic [BLK_W-1:0] granted, t_status status,
                                          logic space_ok);
        plan_row_t row;
        row = ask(cmd, blk, bytes);
        row.checked       = 1'b1;
        row.want.granted  = granted;
        row.want.status   = status;
        row.want.space_ok = space_ok;
        return row;
    endfunction

    function automatic plan_row_t set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        plan_row_t row;
        row      = ask(CMD_NONE, '0, '0);
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    function automatic logic [BLK_W-1:0] pick_free_target();
        int live;
        int start;
        live = live_blocks();
        case ($urandom_range(0, 7))
            0: return BLK_W'($urandom);
            1: return BLK_W'(live);
            2: return BLK_W'(live - 1);
            default: begin
                if (live == 0) return BLK_W'($urandom);
                start = $urandom_range(0, live - 1);
                for (int k = 0; k < live; k++) begin
                    if (block_taken[(start + k) % live]) return BLK_W'((start + k) % live);
                end
                return BLK_W'(start);
            end
        endcase
    endfunction

    function automatic logic [BYTE_CNT_W-1:0] pick_query_bytes();
        logic [31:0] have;
        have = free_bytes();
        case ($urandom_range(0, 5))
            0: return have;
            1: return have + 32'd1;
            2: return have - 32'd1;
            3: return '0;
            4: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic issue(t_cmd cmd, logic [BLK_W-1:0] blk, logic [BYTE_CNT_W-1:0] bytes,
                         logic checked, reply_t want);
        reply_t r;
        i_start        <= 1'b1;
        i_cmd          <= cmd;
        i_block_number <= blk;
        i_byte_count   <= bytes;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        r = serve_request(cmd, blk, bytes);
        awaited.push_back(checked ? want : r);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 23);
            if (!steady) begin
                i_start <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    endtask

    task automatic settle();
        i_start <= 1'b0;
        while (awaited.size() != 0 || o_busy) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_request(int alloc_pct);
        int                    roll;
        t_cmd                  cmd;
        logic [BLK_W-1:0]      blk;
        logic [BYTE_CNT_W-1:0] bytes;
        roll  = $urandom_range(0, 99);
        blk   = BLK_W'($urandom);
        bytes = $urandom;
        if (roll < alloc_pct) begin
            cmd = CMD_ALLOC;
        end else if (roll < 90) begin
            cmd = CMD_FREE;
            blk = pick_free_target();
        end else if (roll < 97) begin
            cmd   = CMD_QUERY;
            bytes = pick_query_bytes();
        end else begin
            cmd = CMD_NONE;
        end
        issue(cmd, blk, bytes, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin : reply_check
        reply_t head;
        if (i_rst_n && o_done) begin
            if (awaited.size() == 0) begin
                $error("reply beat with none awaited: granted_block %0d status %0d space_ok %0d",
                       o_granted_block, o_status, o_space_ok);
                errors++;
            end else begin
                head = awaited.pop_front();
                if (o_granted_block !== head.granted) begin
                    $error("granted_block: expected %0d, actual %0d", head.granted,
                           o_granted_block);
                    errors++;
                end
                if (o_status !== head.status) begin
                    $error("status: expected %0d, actual %0d", head.status, o_status);
                    errors++;
                end
                if (o_space_ok !== head.space_ok) begin
                    $error("space_ok: expected %0d, actual %0d", head.space_ok, o_space_ok);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [CNT_W-1:0]   count_pick;
        logic [BYTES_W-1:0] bytes_pick;
        logic [CFG_W-1:0]   count_data;
        int                 alloc_pct;

        size_per_block = BLOCK_BYTES_RESET;
        count_reg      = BLOCK_COUNT_RESET;
        clear_marks();

        plan.push_back(ask_chk(CMD_QUERY, '0, '0, '0, ST_OK, 1'b1));
        plan.push_back(ask_chk(CMD_QUERY, '1, '1, '0, ST_OK, 1'b0));
        plan.push_back(ask_chk(CMD_QUERY, '0, 32'd524288, '0, ST_OK, 1'b1));
        plan.push_back(ask_chk(CMD_QUERY, '0, 32'd524289, '0, ST_OK, 1'b0));
        plan.push_back(ask_chk(CMD_FREE, '0, '0, '0, ST_ALREADY_FREE, 1'b0));
        plan.push_back(ask_chk(CMD_ALLOC, '1, '1, '0, ST_OK, 1'b0));
        plan.push_back(ask_chk(CMD_ALLOC, '0, '0, BLK_W'(1), ST_OK, 1'b0));
        plan.push_back(ask_chk(CMD_FREE, '0, '0, '0, ST_OK, 1'b0));
        plan.push_back(ask_chk(CMD_ALLOC, '0, '0, '0, ST_OK, 1'b0));
        plan.push_back(ask_chk(CMD_FREE, '1, '1, '0, ST_ALREADY_FREE, 1'b0));
        plan.push_back(ask_chk(CMD_NONE, '1, '1, '0, ST_OK, 1'b0));
        plan.push_back(set_reg(CFG_UNMAPPED_2, '1));
        plan.push_back(set_reg(CFG_UNMAPPED_3, '1));
        plan.push_back(ask(CMD_QUERY, '0, 32'd523264));
        plan.push_back(set_reg(CFG_BLOCK_COUNT, CFG_W'(17'h1F803)));
        plan.push_back(ask_chk(CMD_FREE, BLK_W'(3), '0, '0, ST_RANGE, 1'b0));
        plan.push_back(ask_chk(CMD_FREE, '1, '0, '0, ST_RANGE, 1'b0));
        plan.push_back(ask_chk(CMD_ALLOC, '0, '0, BLK_W'(0), ST_OK, 1'b0));
        plan.push_back(ask_chk(CMD_ALLOC, '0, '0, BLK_W'(1), ST_OK, 1'b0));
        plan.push_back(ask_chk(CMD_ALLOC, '0, '0, BLK_W'(2), ST_OK, 1'b0));
        plan.push_back(ask_chk(CMD_ALLOC, '0, '0, '0, ST_NO_SPACE, 1'b0));
        plan.push_back(ask(CMD_FREE, BLK_W'(1), '0));
        plan.push_back(ask(CMD_ALLOC, '0, '0));
        plan.push_back(set_reg(CFG_BLOCK_BYTES, '0));
        plan.push_back(ask_chk(CMD_QUERY, '0, 32'd1, '0, ST_OK, 1'b0));
        plan.push_back(ask_chk(CMD_QUERY, '0, '0, '0, ST_OK, 1'b1));
        plan.push_back(set_reg(CFG_BLOCK_COUNT, '0));
        plan.push_back(ask_chk(CMD_ALLOC, '0, '0, '0, ST_NO_SPACE, 1'b0));
        plan.push_back(ask_chk(CMD_FREE, '0, '0, '0, ST_RANGE, 1'b0));
        plan.push_back(set_reg(CFG_BLOCK_COUNT, CFG_W'(17'h007FF)));
        plan.push_back(set_reg(CFG_BLOCK_BYTES, '1));
        plan.push_back(ask_chk(CMD_ALLOC, '0, '0, '0, ST_OK, 1'b0));
        plan.push_back(ask(CMD_QUERY, '0, '1));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n]) begin
            if (plan[n].kind == ROW_CFG) begin
                settle();
                write_reg(plan[n].idx, plan[n].data);
            end else begin
                issue(plan[n].cmd, plan[n].blk, plan[n].bytes, plan[n].checked, plan[n].want);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            if (p == 0) begin
                count_pick = CNT_W'(1024);
                bytes_pick = BYTES_W'(65536);
            end else if (p == 1) begin
                count_pick = CNT_W'(1);
                bytes_pick = BYTES_W'(1);
            end else begin
                case ($urandom_range(0, 7))
                    0: count_pick = CNT_W'(1);
                    1: count_pick = CNT_W'(2);
                    2: count_pick = CNT_W'(32);
                    3: count_pick = CNT_W'(33);
                    4: count_pick = CNT_W'(1024);
                    5: count_pick = '1;
                    6: count_pick = '0;
                    default: count_pick = CNT_W'($urandom_range(1, 1024));
                endcase
                case ($urandom_range(0, 5))
                    0: bytes_pick = '0;
                    1: bytes_pick = BYTES_W'(1);
                    2: bytes_pick = BYTES_W'(512);
                    3: bytes_pick = BYTES_W'(65536);
                    4: bytes_pick = '1;
                    default: bytes_pick = BYTES_W'($urandom);
                endcase
            end
            count_data = CFG_W'({6'($urandom), count_pick});
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_BLOCK_BYTES, CFG_W'(bytes_pick));
                write_reg(CFG_BLOCK_COUNT, count_data);
            end else begin
                write_reg(CFG_BLOCK_COUNT, count_data);
                write_reg(CFG_BLOCK_BYTES, CFG_W'(bytes_pick));
            end
            steady    = ($urandom_range(0, 3) == 0);
            alloc_pct = $urandom_range(30, 85);
            for (int n = 0; n < PHASE_ITEMS; n++) random_request(alloc_pct);
        end

        i_start <= 1'b0;
        while (awaited.size() != 0 || o_busy) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && awaited.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/dba_pkg.sv
rtl/core/dba_ram.sv
rtl/core/dba_engine.sv
rtl/core/disk_block_allocator_core.sv
tb/disk_block_allocator_core_tb.sv
